[hdl/fir_filter_mono_macros.svh]
// Assertion helpers shared by the checkers of the FIR block.
// Both expect clk and rst_n in scope.
`ifndef FIR_FILTER_MONO_MACROS_SVH
`define FIR_FILTER_MONO_MACROS_SVH

// Same-cycle implication.
`define FFM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define FFM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ffm_pkg.sv]
package ffm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int IDX_W    = 5;
    localparam int PROD_W   = 2 * SAMPLE_W;
    localparam int FRAC_W   = 15;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = 16'sh7FFF;
    localparam sample_t SAMPLE_MIN = 16'sh8000;

    // request function code
    typedef enum logic {
        FUNC_SAMPLE = 1'b0,
        FUNC_COEF   = 1'b1
    } func_t;

    // per-tap control from the sequencer
    typedef struct packed {
        logic shift;    // move the delay line one tap along
        logic coef_we;  // load coef_value into this tap
    } tap_ctrl_t;

endpackage

[hdl/ffm_tap_cell.sv]
module ffm_tap_cell #(
    parameter int ACC_W = 37
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ffm_pkg::tap_ctrl_t      ctrl,
    input  ffm_pkg::sample_t        sample_prev,
    input  ffm_pkg::sample_t        coef_value,
    input  logic                    vld_in,
    input  logic signed [ACC_W-1:0] psum_in,
    output ffm_pkg::sample_t        sample,
    output logic                    vld_out,
    output logic signed [ACC_W-1:0] psum_out
);

    ffm_pkg::sample_t                     sample_reg, sample_next;
    ffm_pkg::sample_t                     coef_reg, coef_next;
    logic                                 vld_reg;
    logic signed [ACC_W-1:0]              psum_reg, psum_next;
    logic signed [ffm_pkg::PROD_W-1:0]    prod;

    assign prod = ffm_pkg::PROD_W'(sample_reg) * ffm_pkg::PROD_W'(coef_reg);

    always_comb
    begin
        sample_next = ctrl.shift   ? sample_prev : sample_reg;
        coef_next   = ctrl.coef_we ? coef_value  : coef_reg;
        psum_next   = vld_in ? psum_in + ACC_W'(prod) : psum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
            vld_reg    <= 1'b0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
            vld_reg    <= vld_in;
        end
    end

    // partial sum holds once the wave has passed
    always_ff @(posedge clk)
    begin
        psum_reg <= psum_next;
    end

    assign sample   = sample_reg;
    assign vld_out  = vld_reg;
    assign psum_out = psum_reg;

endmodule

[hdl/ffm_out_stage.sv]
module ffm_out_stage #(
    parameter int ACC_W = 37
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  logic signed [ACC_W-1:0] acc,
    input  logic                    out_stall,
    output logic                    free,
    output logic                    out_valid,
    output ffm_pkg::sample_t        left_out,
    output ffm_pkg::sample_t        right_out
);

    localparam logic signed [ACC_W-1:0] BIAS    = ACC_W'((1 << ffm_pkg::FRAC_W) - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(ffm_pkg::SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(ffm_pkg::SAMPLE_MIN);

    logic                    valid_reg, valid_next;
    ffm_pkg::sample_t        y_reg, y_next;
    logic signed [ACC_W-1:0] biased;
    logic signed [ACC_W-1:0] scaled;
    ffm_pkg::sample_t        sat;

    // truncate toward zero: bias negative sums before the arithmetic shift
    assign biased = acc[ACC_W-1] ? acc + BIAS : acc;
    assign scaled = biased >>> ffm_pkg::FRAC_W;

    always_comb
    begin
        if (scaled > SAT_MAX)
            sat = ffm_pkg::SAMPLE_MAX;
        else if (scaled < SAT_MIN)
            sat = ffm_pkg::SAMPLE_MIN;
        else
            sat = scaled[ffm_pkg::SAMPLE_W-1:0];
    end

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        y_next     = y_reg;
        if (load)
        begin
            valid_next = 1'b1;
            y_next     = sat;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        y_reg <= y_next;
    end

    assign out_valid = valid_reg;
    assign left_out  = y_reg;
    assign right_out = y_reg;

endmodule

[hdl/fir_filter_mono.sv]
// Channel  Role     Handshake            Fields
// in       request  in_valid/in_stall    func, sample_in, coef_index, coef_value, overrun
// out      result   out_valid/out_stall  left_out, right_out
//
// A sample request occupies the block while the partial sum walks the tap chain one
// cell per cycle and the finished sum is loaded into the output register.
// Coefficient writes and overrun requests leave the input free and produce nothing.
// Reset clears the delay line, the coefficients and all valid flags.
// A result waiting in the output register does not block new requests; a finished
// sum with no place to go keeps the input stalled until the output register is free.
module fir_filter_mono #(
    parameter int ORDER = 31
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         func,
    input  ffm_pkg::sample_t             sample_in,
    input  logic [ffm_pkg::IDX_W-1:0]    coef_index,
    input  ffm_pkg::sample_t             coef_value,
    input  logic                         overrun,
    output logic                         out_valid,
    input  logic                         out_stall,
    output ffm_pkg::sample_t             left_out,
    output ffm_pkg::sample_t             right_out
);

    localparam int TAPS  = ORDER + 1;
    localparam int ACC_W = ffm_pkg::PROD_W + $clog2(TAPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    state_t                  state_reg, state_next;
    logic                    start_reg, start_next;
    logic                    accept;
    logic                    sample_acc;
    logic                    coef_acc;
    logic                    load;
    logic                    out_free;

    ffm_pkg::tap_ctrl_t      ctrl       [TAPS];
    ffm_pkg::sample_t        sample_chain [TAPS];
    logic                    vld_chain  [TAPS];
    logic signed [ACC_W-1:0] psum_chain [TAPS];

    assign in_stall   = (state_reg != ST_IDLE);
    assign accept     = in_valid && !in_stall;
    assign sample_acc = accept && !overrun && (func == ffm_pkg::FUNC_SAMPLE);
    assign coef_acc   = accept && !overrun && (func == ffm_pkg::FUNC_COEF);

    genvar k;
    generate
        for (k = 0; k < TAPS; k++)
        begin : g_tap
            assign ctrl[k].shift   = sample_acc;
            // taps beyond the index range are never written
            assign ctrl[k].coef_we = coef_acc && (32'(coef_index) == k);

            if (k == 0)
            begin : g_head
                ffm_tap_cell #(.ACC_W(ACC_W)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl[k]),
                    .sample_prev (sample_in),
                    .coef_value  (coef_value),
                    .vld_in      (start_reg),
                    .psum_in     ('0),
                    .sample      (sample_chain[k]),
                    .vld_out     (vld_chain[k]),
                    .psum_out    (psum_chain[k])
                );
            end
            else
            begin : g_body
                ffm_tap_cell #(.ACC_W(ACC_W)) u_cell (
                    .clk         (clk),
                    .rst_n       (rst_n),
                    .ctrl        (ctrl[k]),
                    .sample_prev (sample_chain[k-1]),
                    .coef_value  (coef_value),
                    .vld_in      (vld_chain[k-1]),
                    .psum_in     (psum_chain[k-1]),
                    .sample      (sample_chain[k]),
                    .vld_out     (vld_chain[k]),
                    .psum_out    (psum_chain[k])
                );
            end
        end
    endgenerate

    assign load = ((state_reg == ST_RUN && vld_chain[TAPS-1]) || state_reg == ST_HOLD)
                  && out_free;

    always_comb
    begin
        state_next = state_reg;
        start_next = sample_acc;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_acc)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (vld_chain[TAPS-1])
                    state_next = out_free ? ST_IDLE : ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    ffm_out_stage #(.ACC_W(ACC_W)) u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .acc       (psum_chain[TAPS-1]),
        .out_stall (out_stall),
        .free      (out_free),
        .out_valid (out_valid),
        .left_out  (left_out),
        .right_out (right_out)
    );

endmodule

[hdl/ffm_port_checker.sv]
`include "fir_filter_mono_macros.svh"

module ffm_port_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             func,
    input logic             overrun,
    input logic             out_valid,
    input logic             out_stall,
    input ffm_pkg::sample_t left_out,
    input ffm_pkg::sample_t right_out
);

    logic in_acc;
    logic quick_req;

    assign in_acc    = in_valid && !in_stall;
    assign quick_req = (func == ffm_pkg::FUNC_COEF) || overrun;

    `FFM_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(left_out), "stalled result changed")
    `FFM_ASSERT_IMP(a_lr_equal, out_valid, left_out == right_out, "left and right differ")
    `FFM_ASSERT_NXT(a_sample_busy, in_acc && !quick_req, in_stall,
                    "sample request did not occupy the block")
    `FFM_ASSERT_NXT(a_quick_req, in_acc && quick_req, !in_stall,
                    "coefficient or overrun request stalled the input")
    `FFM_ASSERT_IMP(a_result_src, $rose(out_valid), $past(in_stall),
                    "result appeared without a sample in flight")

endmodule

bind fir_filter_mono ffm_port_checker u_ffm_port_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .overrun   (overrun),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .left_out  (left_out),
    .right_out (right_out)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int ORDER      = 31;
    localparam int IDX_W      = ffm_pkg::IDX_W;
    localparam int QUIET_MAX  = 2000;   // cycles with no transfer before giving up
    localparam int HOLD_LEN   = 300;    // long output hold-off in the pressure test

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 func;
    ffm_pkg::sample_t     sample_in;
    logic [IDX_W-1:0]     coef_index;
    ffm_pkg::sample_t     coef_value;
    logic                 overrun;
    logic                 out_valid;
    logic                 out_stall;
    ffm_pkg::sample_t     left_out;
    ffm_pkg::sample_t     right_out;

    // filter state as the block should hold it
    ffm_pkg::sample_t sample_hist [0:ORDER];
    ffm_pkg::sample_t coef_tab    [0:ORDER];
    ffm_pkg::sample_t pending_filtered [$];

    int fail_count;
    int quiet_cycles;
    int hold_request;
    int hold_left;
    int burst_left;
    bit tx_idle_en;
    bit rx_idle_en;

    fir_filter_mono #(.ORDER(ORDER)) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .overrun    (overrun),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_out   (left_out),
        .right_out  (right_out)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Update the filter state for one accepted request and queue the output of a sample request.
    function automatic void apply_request(input ffm_pkg::func_t f, input ffm_pkg::sample_t s,
                                          input logic [IDX_W-1:0] idx,
                                          input ffm_pkg::sample_t cv, input logic ovr);
        longint acc;
        longint q;
        if (ovr)
            return;
        if (f == ffm_pkg::FUNC_COEF)
        begin
            if (idx <= ORDER)
                coef_tab[idx] = cv;
            return;
        end
        sample_hist[0] = s;
        acc = 0;
        for (int k = 0; k <= ORDER; k++)
            acc += longint'(sample_hist[k]) * longint'(coef_tab[k]);
        for (int k = ORDER; k > 0; k--)
            sample_hist[k] = sample_hist[k-1];
        q = acc / 32768;    // truncates toward zero
        if (q > ffm_pkg::SAMPLE_MAX)
            q = ffm_pkg::SAMPLE_MAX;
        if (q < ffm_pkg::SAMPLE_MIN)
            q = ffm_pkg::SAMPLE_MIN;
        pending_filtered.push_back(ffm_pkg::sample_t'(q));
    endfunction

    function automatic ffm_pkg::sample_t rand_sample();
        if ($urandom_range(0, 3) == 0)
            return ffm_pkg::sample_t'(int'($urandom_range(0, 511)) - 256);
        return ffm_pkg::sample_t'($urandom);
    endfunction

    function automatic ffm_pkg::sample_t rand_coef(input int scale);
        case (scale)
            0:       return ffm_pkg::sample_t'($urandom);
            1:       return ffm_pkg::sample_t'(int'($urandom_range(0, 4095)) - 2048);
            default: return ffm_pkg::sample_t'(int'($urandom_range(0, 127)) - 64);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input ffm_pkg::func_t f, input ffm_pkg::sample_t s,
                                input logic [IDX_W-1:0] idx, input ffm_pkg::sample_t cv,
                                input logic ovr);
        int gap;
        if (tx_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        sample_in  <= s;
        coef_index <= idx;
        coef_value <= cv;
        overrun    <= ovr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        apply_request(f, s, idx, cv, ovr);
        @(negedge clk);
    endtask

    task automatic load_coef(input logic [IDX_W-1:0] idx, input ffm_pkg::sample_t cv);
        send_request(ffm_pkg::FUNC_COEF, rand_sample(), idx, cv, 1'b0);
    endtask

    task automatic filter_in(input ffm_pkg::sample_t s);
        send_request(ffm_pkg::FUNC_SAMPLE, s, IDX_W'($urandom),
                     ffm_pkg::sample_t'($urandom), 1'b0);
    endtask

    task automatic test_zero_coefs;
        filter_in(ffm_pkg::SAMPLE_MAX);
        filter_in(ffm_pkg::SAMPLE_MIN);
        filter_in(16'sd0);
    endtask

    task automatic test_coef_writes;
        load_coef(5'd0, ffm_pkg::SAMPLE_MAX);
        load_coef(5'd31, ffm_pkg::SAMPLE_MIN);
        // overrun requests must leave both tables alone
        send_request(ffm_pkg::FUNC_COEF, 16'sd0, 5'd0, 16'sd0, 1'b1);
        send_request(ffm_pkg::FUNC_SAMPLE, ffm_pkg::SAMPLE_MIN, 5'd31,
                     ffm_pkg::SAMPLE_MAX, 1'b1);
        filter_in(16'sd1);
        filter_in(ffm_pkg::SAMPLE_MAX);
    endtask

    task automatic test_saturation;
        load_coef(5'd1, ffm_pkg::SAMPLE_MAX);
        load_coef(5'd2, ffm_pkg::SAMPLE_MAX);
        repeat (3) filter_in(ffm_pkg::SAMPLE_MAX);
        repeat (3) filter_in(ffm_pkg::SAMPLE_MIN);
    endtask

    task automatic test_truncation;
        load_coef(5'd1, 16'sd0);
        load_coef(5'd2, 16'sd0);
        load_coef(5'd31, 16'sd0);
        load_coef(5'd0, 16'sd1);
        // small negative sums go to zero, not to -1
        filter_in(-16'sd1);
        filter_in(16'sd1);
        filter_in(ffm_pkg::SAMPLE_MIN);
        filter_in(ffm_pkg::SAMPLE_MAX);
    endtask

    // Phases of coefficient loads followed by sample bursts, with some overrun noise.
    task automatic test_random_phases(input int n_items, input bit allow_idle);
        int counted;
        int n_coef;
        int n_samp;
        int scale;
        bit reload;
        counted = 0;
        while (counted < n_items)
        begin
            tx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            rx_idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            scale  = $urandom_range(0, 2);
            reload = ($urandom_range(0, 3) == 0);
            n_coef = reload ? ORDER + 1 : $urandom_range(1, 6);
            for (int i = 0; i < n_coef; i++)
                load_coef(reload ? IDX_W'(i) : IDX_W'($urandom), rand_coef(scale));
            counted += n_coef;
            n_samp = $urandom_range(10, 60);
            for (int i = 0; i < n_samp; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_request(ffm_pkg::func_t'($urandom_range(0, 1)), rand_sample(),
                                 IDX_W'($urandom), rand_coef(0), 1'b1);
                else if ($urandom_range(0, 14) == 0)
                begin
                    load_coef(IDX_W'($urandom), rand_coef(scale));
                    counted++;
                end
                else
                begin
                    filter_in(rand_sample());
                    counted++;
                end
            end
        end
    endtask

    // Output held off long enough that a finished sum waits for the output register and stalls the input.
    task automatic test_output_backpressure;
        tx_idle_en   = 1'b0;
        rx_idle_en   = 1'b0;
        hold_request = HOLD_LEN;
        repeat (80) filter_in(rand_sample());
    endtask

    // result receiver: idle bursts and the long hold-off
    initial
    begin
        out_stall  = 1'b0;
        hold_left  = 0;
        burst_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(1, 6) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        ffm_pkg::sample_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_filtered.size() == 0)
            begin
                $error("unexpected result: left_out=%0d right_out=%0d", left_out, right_out);
                fail_count++;
            end
            else
            begin
                want = pending_filtered.pop_front();
                if (left_out !== want)
                begin
                    $error("left_out: expected %0d, got %0d", want, left_out);
                    fail_count++;
                end
                if (right_out !== want)
                begin
                    $error("right_out: expected %0d, got %0d", want, right_out);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else if (in_valid || pending_filtered.size() != 0)
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $error("no transfer for %0d cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = ffm_pkg::FUNC_SAMPLE;
        sample_in    = '0;
        coef_index   = '0;
        coef_value   = '0;
        overrun      = 1'b0;
        fail_count   = 0;
        quiet_cycles = 0;
        hold_request = 0;
        tx_idle_en   = 1'b1;
        rx_idle_en   = 1'b1;
        for (int k = 0; k <= ORDER; k++)
        begin
            sample_hist[k] = '0;
            coef_tab[k]    = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_zero_coefs;
        test_coef_writes;
        test_saturation;
        test_truncation;
        test_random_phases(1200, 1'b1);
        test_output_backpressure;
        test_random_phases(300, 1'b0);

        in_valid <= 1'b0;
        while (pending_filtered.size() != 0)
            @(posedge clk);
        repeat (ORDER + 8) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
